### hw/rtl/sida_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sida_pkg;

    localparam int VALUE_W   = 32;
    localparam int CHAR_W    = 8;
    localparam int NUM_DIGITS = 10;
    localparam int POS_W     = $clog2(NUM_DIGITS);
    localparam int MULT_W    = VALUE_W + 2;  // holds 9 * 10^9

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(NUM_DIGITS - 1);
    localparam logic [POS_W-1:0] POS_LAST  = '0;

    // powers of ten indexed by digit position
    localparam logic [MULT_W-1:0] POW10 [NUM_DIGITS] = '{
        34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
        34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
    };

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SIGN  = 3'b010,
        S_DIGIT = 3'b100
    } t_state;

    typedef struct packed {
        logic             load;
        logic             sign;
        logic             digit;
        logic [POS_W-1:0] pos;
    } t_cmd;

    typedef struct packed {
        logic neg;
    } t_status;

endpackage

### hw/rtl/sida_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_ctrl
// Sequencer: a sign slot, then ten digit positions from the top down.
// ----------------------------------------------------------------------------
module sida_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sida_pkg::t_status i_status,
    output sida_pkg::t_cmd    o_cmd
);

    sida_pkg::t_state             r_state, n_state;
    logic [sida_pkg::POS_W-1:0]   r_pos, n_pos;
    logic                         w_final;
    logic                         w_load;

    assign w_final = (r_state == sida_pkg::S_DIGIT) && (r_pos == sida_pkg::POS_LAST);
    // a new item may enter during the final digit slot, never while in reset
    assign busy    = !i_rst_n || !((r_state == sida_pkg::S_IDLE) || w_final);
    assign w_load  = start && !busy;

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        case (r_state)
            sida_pkg::S_IDLE: begin
                if (start) begin
                    n_state = sida_pkg::S_SIGN;
                end
            end
            sida_pkg::S_SIGN: begin
                n_state = sida_pkg::S_DIGIT;
                n_pos   = sida_pkg::POS_FIRST;
            end
            sida_pkg::S_DIGIT: begin
                if (r_pos == sida_pkg::POS_LAST) begin
                    n_state = start ? sida_pkg::S_SIGN : sida_pkg::S_IDLE;
                end else begin
                    n_pos = r_pos - 1'b1;
                end
            end
            default: begin
                n_state = sida_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sida_pkg::S_IDLE;
            r_pos   <= sida_pkg::POS_FIRST;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    always_comb begin
        o_cmd.load  = w_load;
        o_cmd.sign  = (r_state == sida_pkg::S_SIGN) && i_status.neg;
        o_cmd.digit = (r_state == sida_pkg::S_DIGIT);
        o_cmd.pos   = r_pos;
    end

endmodule

### hw/rtl/sida_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_datapath
// Magnitude register, one decimal digit per step, output character register.
// ----------------------------------------------------------------------------
module sida_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sida_pkg::t_cmd                i_cmd,
    input  logic [sida_pkg::VALUE_W-1:0]  i_value,
    output sida_pkg::t_status             o_status,
    output logic                          o_strobe,
    output logic [sida_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last_char
);

    logic [sida_pkg::VALUE_W-1:0] r_mag;
    logic                         r_neg;
    logic                         r_seen;
    logic                         r_strobe;
    logic [sida_pkg::CHAR_W-1:0]  r_char;
    logic                         r_last;

    logic [sida_pkg::MULT_W-1:0]  w_pow;
    logic [sida_pkg::MULT_W-1:0]  w_mult;
    logic [sida_pkg::MULT_W-1:0]  w_sub;
    logic [sida_pkg::MULT_W-1:0]  w_mag_ext;
    logic [3:0]                   w_digit;
    logic                         w_emit;

    // digit = largest k with k * 10^pos <= magnitude
    always_comb begin
        w_pow     = sida_pkg::POW10[i_cmd.pos];
        w_mag_ext = {2'b00, r_mag};
        w_digit   = 4'd0;
        w_sub     = '0;
        w_mult    = '0;
        for (int k = 1; k <= 9; k++) begin
            w_mult = w_pow * sida_pkg::MULT_W'(k);
            if (w_mag_ext >= w_mult) begin
                w_digit = 4'(k);
                w_sub   = w_mult;
            end
        end
        // leading zeros are dropped, the units digit always shows
        w_emit = (w_digit != 4'd0) || r_seen || (i_cmd.pos == sida_pkg::POS_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg  <= i_value[sida_pkg::VALUE_W-1];
            r_mag  <= i_value[sida_pkg::VALUE_W-1] ? (~i_value + 1'b1) : i_value;
            r_seen <= 1'b0;
        end else if (i_cmd.digit) begin
            r_mag  <= r_mag - w_sub[sida_pkg::VALUE_W-1:0];
            r_seen <= r_seen || (w_digit != 4'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.sign || (i_cmd.digit && w_emit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sign) begin
            r_char <= sida_pkg::CHAR_MINUS;
            r_last <= 1'b0;
        end else begin
            r_char <= sida_pkg::CHAR_ZERO + {4'd0, w_digit};
            r_last <= (i_cmd.pos == sida_pkg::POS_LAST);
        end
    end

    assign o_status.neg = r_neg;
    assign o_strobe     = r_strobe;
    assign o_char_code  = r_char;
    assign o_last_char  = r_last;

endmodule

### hw/rtl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Formats a signed 32-bit integer as decimal ASCII text, one character
// per cycle at most, most significant first, with the final character flagged.
// ----------------------------------------------------------------------------
// A number is taken when start is high and busy is low. Every number runs
// through eleven fixed slots: a sign slot ('-' shown only for negative
// values) and ten digit slots, one decimal digit per slot from 10^9 down,
// each digit found by one compare-and-subtract step on the magnitude.
// Leading-zero slots produce no character, so characters may arrive with
// gaps. Each character appears for one cycle with o_strobe high and must be
// taken then; there is no way to hold it off. The next number can be taken
// in the last digit slot, before the current number's last character shows;
// its first character comes from the sign slot (negative values) or later.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sida_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_strobe,
    output logic [sida_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last_char
);

    sida_pkg::t_cmd    w_cmd;
    sida_pkg::t_status w_status;

    sida_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    sida_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_value     (i_value),
        .o_status    (w_status),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks signed_int_to_decimal_ascii: numbers go in through the start/busy
// handshake, and every character that comes out is compared with the text
// predicted for the numbers that were taken, in order, with its last flag.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int DRAIN_CYCLES  = 30;
    localparam int MAX_REPORTS   = 10;
    localparam int NUM_CORNERS   = 22;

    localparam int CORNER_VALUES [NUM_CORNERS] = '{
        0, 1, -1, 9, -9, 10, -10, 99, 100, 5,
        999999999, 1000000000, -1000000000, 1000000009,
        2147483647, -2147483647, -2147483647 - 1,
        1234567890, -1234567890, 2000000000, -2147483600, 1010101010
    };

    typedef struct packed {
        logic [sida_pkg::VALUE_W-1:0] value;
        logic [sida_pkg::CHAR_W-1:0]  code;
        logic                         last;
    } t_text_char;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [sida_pkg::VALUE_W-1:0]  i_value;
    logic                          o_strobe;
    logic [sida_pkg::CHAR_W-1:0]   o_char_code;
    logic                          o_last_char;

    t_text_char pending_text [$];

    int mismatches;
    int failures;
    int numbers_taken;
    int negatives_taken;
    int chars_checked;
    int burst_left;

    signed_int_to_decimal_ascii dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // expected text of one number, most significant character first
    function automatic void queue_text(input logic [sida_pkg::VALUE_W-1:0] value);
        logic [sida_pkg::VALUE_W-1:0] magnitude;
        logic [3:0]                   digit_buf [sida_pkg::NUM_DIGITS];
        int                           n_digits;
        t_text_char                   ch;
        magnitude = value[sida_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
        n_digits = 0;
        do begin
            digit_buf[n_digits] = 4'(magnitude % 10);
            magnitude = magnitude / 10;
            n_digits++;
        end while (magnitude != 0 && n_digits < sida_pkg::NUM_DIGITS);
        ch.value = value;
        if (value[sida_pkg::VALUE_W-1]) begin
            ch.code = sida_pkg::CHAR_MINUS;
            ch.last = 1'b0;
            pending_text.push_back(ch);
        end
        for (int i = n_digits - 1; i >= 0; i--) begin
            ch.code = sida_pkg::CHAR_ZERO + {4'd0, digit_buf[i]};
            ch.last = (i == 0);
            pending_text.push_back(ch);
        end
    endfunction

    function automatic logic [sida_pkg::VALUE_W-1:0] pow10_of(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++) p = p * 10;
        return p[sida_pkg::VALUE_W-1:0];
    endfunction

    task automatic send_number(input logic [sida_pkg::VALUE_W-1:0] value);
        @(negedge i_clk);
        start   <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (busy);
        queue_text(value);
        numbers_taken++;
        if (value[sida_pkg::VALUE_W-1]) negatives_taken++;
    endtask

    // sender runs in bursts; between bursts start drops for a random gap
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 30);
            @(negedge i_clk);
            start   <= 1'b0;
            i_value <= $urandom;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic test_extremes();
        for (int i = 0; i < NUM_CORNERS; i++) begin
            send_number(CORNER_VALUES[i]);
            pace();
        end
    endtask

    // pick a digit count first so short and long texts are equally common
    task automatic test_digit_lengths(input int count);
        int                           n_digits;
        logic [sida_pkg::VALUE_W-1:0] lo;
        logic [sida_pkg::VALUE_W-1:0] hi;
        logic [sida_pkg::VALUE_W-1:0] value;
        for (int i = 0; i < count; i++) begin
            n_digits = $urandom_range(1, sida_pkg::NUM_DIGITS);
            lo = (n_digits == 1) ? '0 : pow10_of(n_digits - 1);
            hi = (n_digits == sida_pkg::NUM_DIGITS) ? 32'h7fff_ffff
                                                    : pow10_of(n_digits) - 1;
            case ($urandom_range(0, 5))
                0:       value = lo;
                1:       value = hi;
                default: value = lo + ($urandom % (hi - lo + 1));
            endcase
            if ($urandom_range(0, 1)) value = ~value + 1'b1;
            send_number(value);
            pace();
        end
    endtask

    task automatic test_random_words(input int count);
        for (int i = 0; i < count; i++) begin
            send_number($urandom);
            pace();
        end
    endtask

    // start held high throughout, one item right after another
    task automatic test_back_to_back(input int count);
        for (int i = 0; i < count; i++) begin
            send_number($urandom_range(0, 1) ? $urandom : $urandom_range(0, 999));
        end
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_text_char exp_char;
        if (i_rst_n && o_strobe) begin
            if (pending_text.size() == 0) begin
                failures++;
                if (mismatches < MAX_REPORTS) begin
                    $display("unexpected char 0x%02h last=%0b at %0t",
                             o_char_code, o_last_char, $realtime);
                end
                mismatches++;
            end else begin
                exp_char = pending_text.pop_front();
                chars_checked++;
                if (o_char_code !== exp_char.code || o_last_char !== exp_char.last) begin
                    failures++;
                    if (mismatches < MAX_REPORTS) begin
                        $display("value %0d: expected char 0x%02h last=%0b, %s",
                                 $signed(exp_char.value), exp_char.code, exp_char.last,
                                 $sformatf("got 0x%02h last=%0b",
                                           o_char_code, o_last_char));
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d chars outstanding", pending_text.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_value         = '0;
        mismatches      = 0;
        failures        = 0;
        numbers_taken   = 0;
        negatives_taken = 0;
        chars_checked   = 0;
        burst_left      = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_digit_lengths(88);
        test_random_words(40);
        test_back_to_back(20);

        while (pending_text.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_text.size() != 0) failures++;

        $display("formatted %0d numbers (%0d negative), %0d chars compared, %0d mismatches",
                 numbers_taken, negatives_taken, chars_checked, mismatches);
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
